[rtl/core/ardv_pkg.sv]
// Shared constants for the arithmetic derivative block.
// No dependencies; imported by ardv_divider and the top level.
package ardv_pkg;

  localparam int VALUE_WIDTH = 32;  // bits of the input that are used (4..32)
  localparam int VALUE_PORT_W = 32;  // width of the input port
  localparam int DERIV_W = 37;  // width of the result
  localparam int CNT_W = $clog2(VALUE_WIDTH + 1);
  localparam int SQ_W = VALUE_WIDTH + 2;

endpackage

[rtl/core/ardv_divider.sv]
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on ardv_pkg.
module ardv_divider
  import ardv_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   go_i,
  input  logic [VALUE_WIDTH-1:0] dividend_i,
  input  logic [VALUE_WIDTH-1:0] divisor_i,
  output logic                   done_o,
  output logic [VALUE_WIDTH-1:0] quotient_o,
  output logic [VALUE_WIDTH-1:0] remainder_o
);

  logic                   run_q, run_d;
  logic                   done_q, done_d;
  logic [CNT_W-1:0]       cnt_q, cnt_d;
  logic [VALUE_WIDTH-1:0] rem_q, rem_d;
  logic [VALUE_WIDTH-1:0] quo_q, quo_d;
  logic [VALUE_WIDTH-1:0] div_q, div_d;
  logic [VALUE_WIDTH:0]   trial;
  logic [VALUE_WIDTH:0]   diff;

  assign trial = {rem_q, quo_q[VALUE_WIDTH-1]};
  assign diff  = trial - {1'b0, div_q};

  always_comb begin
    run_d  = run_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    div_d  = div_q;
    if (go_i) begin
      run_d = 1'b1;
      cnt_d = CNT_W'(VALUE_WIDTH);
      rem_d = '0;
      quo_d = dividend_i;
      div_d = divisor_i;
    end else if (run_q) begin
      if (!diff[VALUE_WIDTH]) begin
        rem_d = diff[VALUE_WIDTH-1:0];
        quo_d = {quo_q[VALUE_WIDTH-2:0], 1'b1};
      end else begin
        rem_d = trial[VALUE_WIDTH-1:0];
        quo_d = {quo_q[VALUE_WIDTH-2:0], 1'b0};
      end
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    div_q <= div_d;
  end

  assign done_o      = done_q;
  assign quotient_o  = quo_q;
  assign remainder_o = rem_q;

endmodule

[rtl/core/arithmetic_derivative_trial_division.sv]
// Arithmetic derivative by trial division: sequencer around one shared divider.
// Depends on ardv_pkg and ardv_divider.
//
// channel   ports                      handshake
// input     value_i                    start_i high while busy_o low
// result    derivative_o               valid_o, one cycle, no backpressure
//
// Each division runs on the shared divider. A trial divisor that does not
// divide costs one division and one pass through S_CHECK; a prime factor
// found by trial costs two divisions per occurrence, and the factor left
// above the square root costs one. Worst case is about 2^(VALUE_WIDTH/2)
// trial divisors. Inputs 0 and 1 skip the divider. Reset is asynchronous, active low.
// The receiver cannot stall; busy_o stays high until the result strobe.
module arithmetic_derivative_trial_division
  import ardv_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  output logic                    busy_o,
  input  logic [VALUE_PORT_W-1:0] value_i,
  output logic                    valid_o,
  output logic [DERIV_W-1:0]      derivative_o
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CHECK = 3'd1;
  localparam logic [2:0] S_DIVR  = 3'd2;
  localparam logic [2:0] S_DIVN  = 3'd3;
  localparam logic [2:0] S_DIVF  = 3'd4;

  logic [2:0]             state_q, state_d;
  logic [VALUE_WIDTH-1:0] n_q, n_d;
  logic [VALUE_WIDTH-1:0] rest_q, rest_d;
  logic [VALUE_WIDTH-1:0] d_q, d_d;
  logic [SQ_W-1:0]        sq_q, sq_d;
  logic [DERIV_W-1:0]     sum_q, sum_d;
  logic                   valid_q, valid_d;
  logic [DERIV_W-1:0]     out_q, out_d;

  logic                   div_go;
  logic [VALUE_WIDTH-1:0] div_a, div_b;
  logic                   div_done;
  logic [VALUE_WIDTH-1:0] div_quo, div_rem;
  logic [VALUE_WIDTH-1:0] in_val;
  logic [DERIV_W-1:0]     quo_ext;

  assign in_val  = value_i[VALUE_WIDTH-1:0];
  assign quo_ext = {{(DERIV_W-VALUE_WIDTH){1'b0}}, div_quo};

  ardv_divider u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .go_i        (div_go),
    .dividend_i  (div_a),
    .divisor_i   (div_b),
    .done_o      (div_done),
    .quotient_o  (div_quo),
    .remainder_o (div_rem)
  );

  always_comb begin
    state_d = state_q;
    n_d     = n_q;
    rest_d  = rest_q;
    d_d     = d_q;
    sq_d    = sq_q;
    sum_d   = sum_q;
    valid_d = 1'b0;
    out_d   = out_q;
    div_go  = 1'b0;
    div_a   = n_q;
    div_b   = d_q;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          n_d    = in_val;
          rest_d = in_val;
          d_d    = VALUE_WIDTH'(2);
          sq_d   = SQ_W'(4);
          sum_d  = '0;
          if (in_val <= VALUE_WIDTH'(1)) begin
            valid_d = 1'b1;
            out_d   = '0;
          end else begin
            state_d = S_CHECK;
          end
        end
      end
      S_CHECK: begin
        if (sq_q > {2'b00, rest_q}) begin
          if (rest_q > VALUE_WIDTH'(1)) begin
            div_go  = 1'b1;
            div_a   = n_q;
            div_b   = rest_q;
            state_d = S_DIVF;
          end else begin
            valid_d = 1'b1;
            out_d   = sum_q;
            state_d = S_IDLE;
          end
        end else begin
          div_go  = 1'b1;
          div_a   = rest_q;
          div_b   = d_q;
          state_d = S_DIVR;
        end
      end
      S_DIVR: begin
        if (div_done) begin
          if (div_rem == '0) begin
            rest_d  = div_quo;
            div_go  = 1'b1;
            div_a   = n_q;
            div_b   = d_q;
            state_d = S_DIVN;
          end else begin
            d_d     = d_q + VALUE_WIDTH'(1);
            sq_d    = sq_q + {1'b0, d_q, 1'b1};
            state_d = S_CHECK;
          end
        end
      end
      S_DIVN: begin
        if (div_done) begin
          sum_d   = sum_q + quo_ext;
          state_d = S_CHECK;
        end
      end
      S_DIVF: begin
        if (div_done) begin
          valid_d = 1'b1;
          out_d   = sum_q + quo_ext;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q    <= n_d;
    rest_q <= rest_d;
    d_q    <= d_d;
    sq_q   <= sq_d;
    sum_q  <= sum_d;
    out_q  <= out_d;
  end

  assign busy_o       = (state_q != S_IDLE);
  assign valid_o      = valid_q;
  assign derivative_o = out_q;

endmodule
